>>> design/rbbr_pkg.sv
`timescale 1ns / 1ps

package rbbr_pkg;

  localparam int RBBR_MAX_SLOTS_DEF = 4096;

  localparam int OPCODE_W     = 3;
  localparam int COUNT_W      = 13;
  localparam int STATUS_W     = 2;
  localparam int OFFSET_W     = 28;
  localparam int STRIDE_W     = 16;
  localparam int SLOT_COUNT_W = 13;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [SLOT_COUNT_W-1:0] RESET_SLOT_COUNT = 13'd4096;
  localparam logic [STRIDE_W-1:0]     RESET_STRIDE     = 16'd1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_STRIDE = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_RES_INS    = 3'd0,
    OP_COMMIT_INS = 3'd1,
    OP_FORCE_INS  = 3'd2,
    OP_RES_REM    = 3'd3,
    OP_COMMIT_REM = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2,
    ST_NOSPACE = 2'd3
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic [OFFSET_W-1:0]       byte_offset;
    logic [COUNT_W-1:0]        available;
    logic [COUNT_W-1:0]        space;
    logic                      is_empty;
  } rbbr_result_t;

endpackage

>>> design/rbbr_if.sv
`timescale 1ns / 1ps

interface rbbr_in_if import rbbr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output opcode, output count, input ready);
  modport sink   (input valid, input opcode, input count, output ready);
endinterface

interface rbbr_out_if import rbbr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] byte_offset;
  logic [COUNT_W-1:0]  available;
  logic [COUNT_W-1:0]  space;
  logic                is_empty;

  modport source (output valid, output status, output byte_offset, output available,
                  output space, output is_empty, input ready);
  modport sink   (input valid, input status, input byte_offset, input available,
                  input space, input is_empty, output ready);
endinterface

>>> design/rbbr_cfg.sv
`timescale 1ns / 1ps

module rbbr_cfg import rbbr_pkg::*; #(
  parameter int MAX_SLOTS = RBBR_MAX_SLOTS_DEF,
  parameter int CW        = 13
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic [CW-1:0]          slots_r,
  output logic [STRIDE_W-1:0]    stride_r,
  output logic                   ring_clear
);

  // clamp a slot count to 1..MAX_SLOTS
  function automatic logic [CW-1:0] clamp_slots(input logic [SLOT_COUNT_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w == '0) begin
      w = CW'(1);
    end else if (w > CW'(MAX_SLOTS)) begin
      w = CW'(MAX_SLOTS);
    end
    return w;
  endfunction

  assign ring_clear = cfg_we && (cfg_index == CFG_SLOT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r  <= clamp_slots(RESET_SLOT_COUNT);
      stride_r <= RESET_STRIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOT_COUNT:  slots_r  <= clamp_slots(cfg_wdata[SLOT_COUNT_W-1:0]);
        CFG_SLOT_STRIDE: stride_r <= cfg_wdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/rbbr_ring.sv
`timescale 1ns / 1ps

module rbbr_ring import rbbr_pkg::*; #(
  parameter int PW        = 12,
  parameter int CW        = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  logic                step_en,
  input  logic [CW-1:0]       slots,
  input  logic [STRIDE_W-1:0] stride,
  input  logic [OPCODE_W-1:0] op,
  input  logic [COUNT_W-1:0]  cnt,
  output rbbr_result_t        result
);

  logic [PW-1:0] ip_r, ip_nxt, rp_r, rp_nxt;
  logic          empty_r, empty_nxt;
  logic          ins_pend_r, ins_pend_nxt, rem_pend_r, rem_pend_nxt;
  logic [CW-1:0] ins_res_r, ins_res_nxt, rem_res_r, rem_res_nxt;
  // readable slots, kept next to the pointers so no step recomputes them
  logic [CW-1:0] avail_r, avail_nxt;

  logic [CW-1:0]        n_w, sp_cur;
  status_t              status;
  logic                 off_en, off_rem;
  logic [PW+STRIDE_W-1:0] prod;

  // advance a pointer by at most one ring length
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                             input logic [CW-1:0] k,
                                             input logic [CW-1:0] s);
    logic [CW:0] sum;
    sum = (CW+1)'(p) + (CW+1)'(k);
    if (sum >= {1'b0, s}) begin
      sum = sum - {1'b0, s};
    end
    return PW'(sum);
  endfunction

  always_comb begin
    n_w          = CW'(cnt);
    sp_cur       = slots - avail_r;
    ip_nxt       = ip_r;
    rp_nxt       = rp_r;
    empty_nxt    = empty_r;
    ins_pend_nxt = ins_pend_r;
    rem_pend_nxt = rem_pend_r;
    ins_res_nxt  = ins_res_r;
    rem_res_nxt  = rem_res_r;
    avail_nxt    = avail_r;
    status       = ST_OK;
    off_en       = 1'b0;
    off_rem      = 1'b0;

    case (opcode_t'(op))
      OP_RES_INS, OP_FORCE_INS: begin
        if (cnt == '0) begin
          status = ST_INVALID;
        end else if (ins_pend_r) begin
          status = ST_BUSY;
        end else if (n_w > sp_cur && opcode_t'(op) == OP_RES_INS) begin
          status = ST_NOSPACE;
        end else if (n_w > sp_cur && rem_pend_r) begin
          status = ST_BUSY;
        end else if (n_w > sp_cur && n_w > slots) begin
          status = ST_NOSPACE;
        end else begin
          if (n_w > sp_cur) begin
            // drop the oldest entries to make room; what is left is slots - count
            rp_nxt      = wrap_add(rp_r, n_w - sp_cur, slots);
            rem_res_nxt = '0;
            avail_nxt   = slots - n_w;
            empty_nxt   = (n_w == slots);
          end
          ins_res_nxt  = n_w;
          ins_pend_nxt = 1'b1;
          off_en       = 1'b1;
        end
      end
      OP_COMMIT_INS: begin
        if (ins_pend_r) begin
          ip_nxt       = wrap_add(ip_r, ins_res_r, slots);
          avail_nxt    = avail_r + ins_res_r;
          ins_res_nxt  = '0;
          ins_pend_nxt = 1'b0;
          empty_nxt    = 1'b0;
        end
      end
      OP_RES_REM: begin
        if (cnt == '0) begin
          status = ST_INVALID;
        end else if (rem_pend_r) begin
          status = ST_BUSY;
        end else if (n_w > avail_r) begin
          status = ST_NOSPACE;
        end else begin
          rem_res_nxt  = n_w;
          rem_pend_nxt = 1'b1;
          off_en       = 1'b1;
          off_rem      = 1'b1;
        end
      end
      OP_COMMIT_REM: begin
        if (rem_pend_r) begin
          rp_nxt       = wrap_add(rp_r, rem_res_r, slots);
          avail_nxt    = avail_r - rem_res_r;
          rem_res_nxt  = '0;
          rem_pend_nxt = 1'b0;
          if (avail_r == rem_res_r) begin
            empty_nxt = 1'b1;
          end
        end
      end
      default: status = ST_INVALID;
    endcase

    prod   = (PW+STRIDE_W)'(off_rem ? rp_r : ip_r) * (PW+STRIDE_W)'(stride);

    result.status      = status;
    result.byte_offset = off_en ? OFFSET_W'(prod) : '0;
    result.available   = COUNT_W'(avail_nxt);
    result.space       = COUNT_W'(slots - avail_nxt);
    result.is_empty    = empty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      ip_r       <= '0;
      rp_r       <= '0;
      empty_r    <= 1'b1;
      ins_pend_r <= 1'b0;
      rem_pend_r <= 1'b0;
      ins_res_r  <= '0;
      rem_res_r  <= '0;
      avail_r    <= '0;
    end else if (step_en) begin
      ip_r       <= ip_nxt;
      rp_r       <= rp_nxt;
      empty_r    <= empty_nxt;
      ins_pend_r <= ins_pend_nxt;
      rem_pend_r <= rem_pend_nxt;
      ins_res_r  <= ins_res_nxt;
      rem_res_r  <= rem_res_nxt;
      avail_r    <= avail_nxt;
    end
  end

endmodule

>>> design/ring_buffer_block_reservation.sv
`timescale 1ns / 1ps
// An accepted item passes through the input register and then the result register.
// Throughput: 1 item per cycle while the result channel is not stalled; the ring state update and the offset multiply
//   (pointer times stride) both fit between the input and result registers.
// Reset (rst_n low, synchronous): pointers zero, ring empty, nothing pending,
//   slot_count 4096 (clamped to MAX_SLOTS), slot_stride 1, both channels empty.
module ring_buffer_block_reservation import rbbr_pkg::*; #(
  parameter int MAX_SLOTS = RBBR_MAX_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  rbbr_in_if.sink                in_chan,
  rbbr_out_if.source             out_chan,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // pointer width and slot-count width (wide enough for MAX_SLOTS itself)
  localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = ($clog2(MAX_SLOTS + 1) > COUNT_W) ? $clog2(MAX_SLOTS + 1) : COUNT_W;

  logic [CW-1:0]       slots;
  logic [STRIDE_W-1:0] stride;
  logic                ring_clear;

  // input register
  logic                s1_valid_r;
  logic [OPCODE_W-1:0] s1_op_r;
  logic [COUNT_W-1:0]  s1_cnt_r;

  // result register
  logic                out_valid_r;
  rbbr_result_t        out_res_r;
  rbbr_result_t        step_res;

  logic                advance;

  // Move the held item into the result register when that register is free
  // or being drained this cycle.
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  rbbr_cfg #(
    .MAX_SLOTS (MAX_SLOTS),
    .CW        (CW)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .slots_r    (slots),
    .stride_r   (stride),
    .ring_clear (ring_clear)
  );

  rbbr_ring #(
    .PW        (PW),
    .CW        (CW)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (ring_clear),
    .step_en (advance),
    .slots   (slots),
    .stride  (stride),
    .op      (s1_op_r),
    .cnt     (s1_cnt_r),
    .result  (step_res)
  );

  // Hold the item until its result can be registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_op_r  <= in_chan.opcode;
      s1_cnt_r <= in_chan.count;
    end
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_res_r.status;
  assign out_chan.byte_offset = out_res_r.byte_offset;
  assign out_chan.available   = out_res_r.available;
  assign out_chan.space       = out_res_r.space;
  assign out_chan.is_empty    = out_res_r.is_empty;

endmodule

>>> design/rbbr_checker.sv
`timescale 1ns / 1ps

module rbbr_checker import rbbr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [OFFSET_W-1:0] out_byte_offset
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_byte_offset))
    else $error("stalled result changed");

  // reset empties the result channel
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an item taken while the result side is empty reaches it through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // one item of slack behind a stalled result, then backpressure
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && in_valid && in_ready |=> out_ready || !in_ready)
    else $error("input still ready with result stalled and input register full");

endmodule

bind ring_buffer_block_reservation rbbr_checker u_rbbr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_byte_offset (out_chan.byte_offset)
);
